// ===== sv/mwm_pkg.sv =====
// Shared types and constants of the mecanum wheel mixer.
// Depends on nothing; mwm_mix, mwm_div and the top level refer to it by scoped names.
`timescale 1ns / 1ps

package mwm_pkg;

	// Field widths
	localparam int CMD_W  = 16;   // velocity command fields
	localparam int LIM_W  = 14;   // component limit registers
	localparam int WLIM_W = 15;   // wheel limit register
	localparam int SAT_W  = 15;   // saturated component, +/-16383
	localparam int MIX_W  = 17;   // raw wheel mix, +/-49149
	localparam int MAG_W  = 16;   // magnitude of a raw mix
	localparam int PROD_W = MAG_W + WLIM_W;
	localparam int Q_W    = WLIM_W; // scaled magnitude never exceeds the wheel limit
	localparam int OUT_W  = 16;
	localparam int WHEELS = 4;

	// Divider pipeline: quotient bits resolved per stage
	localparam int DIV_BPS    = 3;
	localparam int DIV_STAGES = (Q_W + DIV_BPS - 1) / DIV_BPS;

	// Register indexes
	localparam int IDX_W = 2;
	localparam logic [IDX_W-1:0] REG_LIMIT_VX    = 2'd0;
	localparam logic [IDX_W-1:0] REG_LIMIT_VY    = 2'd1;
	localparam logic [IDX_W-1:0] REG_LIMIT_OMEGA = 2'd2;
	localparam logic [IDX_W-1:0] REG_LIMIT_WHEEL = 2'd3;

	// Reset values of the limit registers
	localparam logic [LIM_W-1:0]  RST_LIMIT_VX    = 14'd3000;
	localparam logic [LIM_W-1:0]  RST_LIMIT_VY    = 14'd4500;
	localparam logic [LIM_W-1:0]  RST_LIMIT_OMEGA = 14'd3600;
	localparam logic [WLIM_W-1:0] RST_LIMIT_WHEEL = 15'd4500;

	typedef struct packed {
		logic signed [CMD_W-1:0] vel_x;
		logic signed [CMD_W-1:0] vel_y;
		logic signed [CMD_W-1:0] rot_rate;
	} cmd_t;

	typedef struct packed {
		logic signed [OUT_W-1:0] wheel_fr;
		logic signed [OUT_W-1:0] wheel_fl;
		logic signed [OUT_W-1:0] wheel_bl;
		logic signed [OUT_W-1:0] wheel_br;
	} wheel_t;

	typedef struct packed {
		logic [IDX_W-1:0]  idx;
		logic [WLIM_W-1:0] wdata;
	} cfg_t;

	typedef struct packed {
		logic [LIM_W-1:0]  vx;
		logic [LIM_W-1:0]  vy;
		logic [LIM_W-1:0]  om;
		logic [WLIM_W-1:0] wheel;
	} lim_t;

	// Mixer front end to divider: products plus pass-through data per wheel
	typedef struct packed {
		logic [WHEELS-1:0][PROD_W-1:0] prod;
		logic [WHEELS-1:0][OUT_W-1:0]  w16;
		logic [WHEELS-1:0]             neg;
		logic [MAG_W-1:0]              m;
		logic                          scale;
	} mix_out_t;

	// One divider pipeline stage
	typedef struct packed {
		logic [WHEELS-1:0][PROD_W-1:0] rem;
		logic [WHEELS-1:0][Q_W-1:0]    q;
		logic [WHEELS-1:0][OUT_W-1:0]  w16;
		logic [WHEELS-1:0]             neg;
		logic [MAG_W-1:0]              m;
		logic                          scale;
	} div_t;

endpackage

// ===== sv/mwm_stream_if.sv =====
// Valid/ready channel carrying one payload beat of type T.
// Used for the command, wheel and configuration channels; payload types come from mwm_pkg.
`timescale 1ns / 1ps

interface mwm_stream_if #(
	parameter type T = logic
) ();
	logic valid;
	logic ready;
	T     data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

// ===== sv/mwm_mix.sv =====
// Front end of the mixer: saturate, mix, find peak magnitude, form scale products.
// Four register stages (s1..s4); types and widths from mwm_pkg.
`timescale 1ns / 1ps

module mwm_mix (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  mwm_pkg::cmd_t     in_data,
	input  mwm_pkg::lim_t     lim,
	output logic              out_valid,
	input  logic              out_ready,
	output mwm_pkg::mix_out_t out_data
);

	localparam int W = mwm_pkg::WHEELS;

	// Clamp a command to +/- its limit
	function automatic logic signed [mwm_pkg::SAT_W-1:0] clamp_sym(
		logic signed [mwm_pkg::CMD_W-1:0] v,
		logic [mwm_pkg::LIM_W-1:0] l
	);
		logic signed [mwm_pkg::CMD_W:0] ve;
		logic signed [mwm_pkg::CMD_W:0] le;
		logic signed [mwm_pkg::CMD_W:0] r;
		ve = (mwm_pkg::CMD_W+1)'(v);
		le = signed'((mwm_pkg::CMD_W+1)'(l));
		if (ve > le) r = le;
		else if (ve < -le) r = -le;
		else r = ve;
		return mwm_pkg::SAT_W'(r);
	endfunction

	logic valid_s1, valid_s2, valid_s3, valid_s4;
	logic r1, r2, r3, r4;

	logic signed [mwm_pkg::SAT_W-1:0] vx_s1, vy_s1, om_s1;
	logic signed [mwm_pkg::MIX_W-1:0] w_s2 [W];
	logic        [mwm_pkg::MAG_W-1:0] mag_s2 [W];
	logic signed [mwm_pkg::MIX_W-1:0] w_s3 [W];
	logic        [mwm_pkg::MAG_W-1:0] mag_s3 [W];
	logic        [mwm_pkg::MAG_W-1:0] m_s3;
	logic                             scale_s3;
	logic        [mwm_pkg::PROD_W-1:0] prod_s4 [W];
	logic        [mwm_pkg::OUT_W-1:0]  w16_s4 [W];
	logic        [W-1:0]               neg_s4;
	logic        [mwm_pkg::MAG_W-1:0]  m_s4;
	logic                              scale_s4;

	logic signed [mwm_pkg::MIX_W-1:0] x, y, o;
	logic signed [mwm_pkg::MIX_W-1:0] w_c [W];
	logic        [mwm_pkg::MAG_W-1:0] mag_c [W];
	logic        [mwm_pkg::MAG_W-1:0] m01, m23, m_c;

	// Per-stage ready: a stage advances when empty or when its successor takes
	assign r4 = !valid_s4 || out_ready;
	assign r3 = !valid_s3 || r4;
	assign r2 = !valid_s2 || r3;
	assign r1 = !valid_s1 || r2;
	assign in_ready = r1;

	// Valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else begin
			if (r1) valid_s1 <= in_valid;
			if (r2) valid_s2 <= valid_s1;
			if (r3) valid_s3 <= valid_s2;
			if (r4) valid_s4 <= valid_s3;
		end
	end

	// Stage 1: saturate each component
	always_ff @(posedge clk) begin
		if (r1 && in_valid) begin
			vx_s1 <= clamp_sym(in_data.vel_x, lim.vx);
			vy_s1 <= clamp_sym(in_data.vel_y, lim.vy);
			om_s1 <= clamp_sym(in_data.rot_rate, lim.om);
		end
	end

	// Stage 2: mix into four wheels and take magnitudes
	always_comb begin
		x = mwm_pkg::MIX_W'(vx_s1);
		y = mwm_pkg::MIX_W'(vy_s1);
		o = mwm_pkg::MIX_W'(om_s1);
		w_c[0] = -x + y - o;
		w_c[1] = -x - y - o;
		w_c[2] =  x - y - o;
		w_c[3] =  x + y - o;
		for (int i = 0; i < W; i++) begin
			mag_c[i] = w_c[i][mwm_pkg::MIX_W-1] ? mwm_pkg::MAG_W'(-w_c[i])
			                                    : mwm_pkg::MAG_W'(w_c[i]);
		end
	end

	always_ff @(posedge clk) begin
		if (r2 && valid_s1) begin
			w_s2   <= w_c;
			mag_s2 <= mag_c;
		end
	end

	// Stage 3: peak magnitude and scale decision
	always_comb begin
		m01 = (mag_s2[0] > mag_s2[1]) ? mag_s2[0] : mag_s2[1];
		m23 = (mag_s2[2] > mag_s2[3]) ? mag_s2[2] : mag_s2[3];
		m_c = (m01 > m23) ? m01 : m23;
	end

	always_ff @(posedge clk) begin
		if (r3 && valid_s2) begin
			w_s3     <= w_s2;
			mag_s3   <= mag_s2;
			m_s3     <= m_c;
			scale_s3 <= m_c > mwm_pkg::MAG_W'(lim.wheel);
		end
	end

	// Stage 4: magnitude times wheel limit
	always_ff @(posedge clk) begin
		if (r4 && valid_s3) begin
			for (int i = 0; i < W; i++) begin
				prod_s4[i] <= mwm_pkg::PROD_W'(mag_s3[i]) * mwm_pkg::PROD_W'(lim.wheel);
				w16_s4[i]  <= w_s3[i][mwm_pkg::OUT_W-1:0];
				neg_s4[i]  <= w_s3[i][mwm_pkg::MIX_W-1];
			end
			m_s4     <= m_s3;
			scale_s4 <= scale_s3;
		end
	end

	assign out_valid = valid_s4;

	always_comb begin
		for (int i = 0; i < W; i++) begin
			out_data.prod[i] = prod_s4[i];
			out_data.w16[i]  = w16_s4[i];
		end
		out_data.neg   = neg_s4;
		out_data.m     = m_s4;
		out_data.scale = scale_s4;
	end

endmodule

// ===== sv/mwm_div.sv =====
// Back end of the mixer: pipelined restoring divider of product by peak magnitude,
// then sign restore and output register. Types and stage counts from mwm_pkg.
`timescale 1ns / 1ps

module mwm_div (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  mwm_pkg::mix_out_t in_data,
	output logic              out_valid,
	input  logic              out_ready,
	output mwm_pkg::wheel_t   out_data
);

	localparam int W  = mwm_pkg::WHEELS;
	localparam int NS = mwm_pkg::DIV_STAGES;

	// Resolve DIV_BPS quotient bits of every lane, top bit first
	function automatic mwm_pkg::div_t div_step(mwm_pkg::div_t d, int stage);
		mwm_pkg::div_t r;
		logic [mwm_pkg::PROD_W-1:0] dsh;
		int k;
		r = d;
		for (int b = 0; b < mwm_pkg::DIV_BPS; b++) begin
			k = mwm_pkg::Q_W - 1 - stage * mwm_pkg::DIV_BPS - b;
			if (k >= 0) begin
				for (int i = 0; i < W; i++) begin
					dsh = mwm_pkg::PROD_W'(r.m) << k;
					if (r.rem[i] >= dsh) begin
						r.rem[i] = r.rem[i] - dsh;
						r.q[i]   = r.q[i] | (mwm_pkg::Q_W'(1) << k);
					end
				end
			end
		end
		return r;
	endfunction

	mwm_pkg::div_t div_s  [NS];
	logic          vld_s  [NS];
	logic          rdy    [NS];
	mwm_pkg::div_t div_in [NS];
	mwm_pkg::div_t first;

	mwm_pkg::wheel_t wheel_s10;
	logic            valid_s10;
	logic            rdy_out;
	logic [mwm_pkg::OUT_W-1:0] lane [W];

	// Load the remainder with the product, quotient empty
	always_comb begin
		first.rem   = in_data.prod;
		first.q     = '0;
		first.w16   = in_data.w16;
		first.neg   = in_data.neg;
		first.m     = in_data.m;
		first.scale = in_data.scale;
	end

	assign rdy_out  = !valid_s10 || out_ready;
	assign in_ready = rdy[0];

	for (genvar j = 0; j < NS; j++) begin : g_stage
		if (j == 0) begin : g_head
			assign div_in[j] = first;
		end else begin : g_body
			assign div_in[j] = div_s[j-1];
		end

		if (j == NS - 1) begin : g_tail
			assign rdy[j] = !vld_s[j] || rdy_out;
		end else begin : g_mid
			assign rdy[j] = !vld_s[j] || rdy[j+1];
		end

		// Advance valid bit
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[j] <= 1'b0;
			end else if (rdy[j]) begin
				vld_s[j] <= (j == 0) ? in_valid : vld_s[j == 0 ? 0 : j-1];
			end
		end

		// Advance payload
		always_ff @(posedge clk) begin
			if (rdy[j] && ((j == 0) ? in_valid : vld_s[j == 0 ? 0 : j-1])) begin
				div_s[j] <= div_step(div_in[j], j);
			end
		end
	end

	// Restore sign of scaled lanes, pass the rest through
	always_comb begin
		for (int i = 0; i < W; i++) begin
			if (div_s[NS-1].scale) begin
				lane[i] = div_s[NS-1].neg[i] ? -mwm_pkg::OUT_W'(div_s[NS-1].q[i])
				                             :  mwm_pkg::OUT_W'(div_s[NS-1].q[i]);
			end else begin
				lane[i] = div_s[NS-1].w16[i];
			end
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s10 <= 1'b0;
		end else if (rdy_out) begin
			valid_s10 <= vld_s[NS-1];
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_out && vld_s[NS-1]) begin
			wheel_s10.wheel_fr <= signed'(lane[0]);
			wheel_s10.wheel_fl <= signed'(lane[1]);
			wheel_s10.wheel_bl <= signed'(lane[2]);
			wheel_s10.wheel_br <= signed'(lane[3]);
		end
	end

	assign out_valid = valid_s10;
	assign out_data  = wheel_s10;

endmodule

// ===== sv/mecanum_wheel_mixer_unit.sv =====
// Mecanum wheel mixer top level: limit registers, front end and divider pipeline.
// Depends on mwm_pkg, mwm_stream_if, mwm_mix and mwm_div.
`timescale 1ns / 1ps

// Usage
// cmd   (sink):   one chassis command beat (vel_x, vel_y, rot_rate) per valid/ready beat.
// wheel (source): one beat of four wheel speeds per command, in command order.
// cfg   (sink):   register writes, idx 0..3 = limit_vx, limit_vy, limit_omega,
//                 limit_wheel; always ready, write lands at the accepting edge.
//                 Write only while no command is in flight.
// Each command saturates its components, mixes them into four wheels and, when
// the peak magnitude exceeds limit_wheel, scales every wheel by limit_wheel/peak
// toward zero.
// Pipeline: 4 front-end stages, 5 divider stages resolving 3 quotient bits each,
// and one output register lie between command beat and wheel beat.
// Throughput: one command per cycle while the wheel side does not stall; the divider is fully pipelined per lane.
// Stall: each stage holds its beat while the next is full, so a stalled receiver
// backs the pipeline up stage by stage; cmd.ready drops only when all 10 stages
// are full. Nothing is dropped or repeated.
// Reset: arst_n clears all valid bits and loads the limits with 3000, 4500,
// 3600 and 4500.

module mecanum_wheel_mixer_unit (
	input  logic          clk,
	input  logic          arst_n,
	mwm_stream_if.sink    cmd,
	mwm_stream_if.source  wheel,
	mwm_stream_if.sink    cfg
);

	mwm_pkg::lim_t     lim_q;
	mwm_pkg::mix_out_t mix_data;
	logic              mix_valid;
	logic              mix_ready;

	// Limit registers
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lim_q.vx    <= mwm_pkg::RST_LIMIT_VX;
			lim_q.vy    <= mwm_pkg::RST_LIMIT_VY;
			lim_q.om    <= mwm_pkg::RST_LIMIT_OMEGA;
			lim_q.wheel <= mwm_pkg::RST_LIMIT_WHEEL;
		end else if (cfg.valid && cfg.ready) begin
			unique case (cfg.data.idx)
				mwm_pkg::REG_LIMIT_VX:    lim_q.vx    <= cfg.data.wdata[mwm_pkg::LIM_W-1:0];
				mwm_pkg::REG_LIMIT_VY:    lim_q.vy    <= cfg.data.wdata[mwm_pkg::LIM_W-1:0];
				mwm_pkg::REG_LIMIT_OMEGA: lim_q.om    <= cfg.data.wdata[mwm_pkg::LIM_W-1:0];
				mwm_pkg::REG_LIMIT_WHEEL: lim_q.wheel <= cfg.data.wdata;
				default: ;
			endcase
		end
	end

	mwm_mix u_mix (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (cmd.valid),
		.in_ready  (cmd.ready),
		.in_data   (cmd.data),
		.lim       (lim_q),
		.out_valid (mix_valid),
		.out_ready (mix_ready),
		.out_data  (mix_data)
	);

	mwm_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (mix_valid),
		.in_ready  (mix_ready),
		.in_data   (mix_data),
		.out_valid (wheel.valid),
		.out_ready (wheel.ready),
		.out_data  (wheel.data)
	);

	// Input backs up only when the whole pipeline is full behind a stalled output
	a_stall_only_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		!cmd.ready |-> (wheel.valid && !wheel.ready))
		else $error("command side stalled with room in the pipeline");

	// Scaled or passed wheels never reach the most negative 16-bit code
	a_wheel_range: assert property (@(posedge clk) disable iff (!arst_n)
		wheel.valid |-> (wheel.data.wheel_fr != 16'sh8000) &&
		                (wheel.data.wheel_fl != 16'sh8000) &&
		                (wheel.data.wheel_bl != 16'sh8000) &&
		                (wheel.data.wheel_br != 16'sh8000))
		else $error("wheel speed out of range");

	// A mix beat waiting on the divider means the divider's entry stage is full
	a_mix_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(mix_valid && !mix_ready) |=> mix_valid)
		else $error("front end dropped a beat under stall");

endmodule
